>>> hdl/rgb_to_hsv_converter_assert.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Checks on posedge clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// consequent checked in the same cycle
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the following cycle
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Widths, constants and types shared by the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHAN_W      = 8;
  localparam int CHAN_LEVELS = 1 << CHAN_W;
  localparam int HUE_W       = 16;
  localparam int SAT_W       = 16;

  // sector sum n < 6*delta
  localparam int N_W         = 11;
  // 65536*n + 3*delta
  localparam int HUE_NUM_W   = 27;
  // 131070*delta + max
  localparam int SAT_NUM_W   = 25;
  // 6*delta and 2*max
  localparam int HUE_DIV_W   = 11;
  localparam int SAT_DIV_W   = 9;
  // quotient estimates
  localparam int HUE_Q_W     = 17;
  localparam int SAT_Q_W     = 16;

  localparam int RCP_W       = 32;
  localparam logic [RCP_W:0] RCP_ONE = {1'b1, {RCP_W{1'b0}}};

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [CHAN_W-1:0]    brightness;
    logic [CHAN_W-1:0]    delta;
    logic                 grey;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [SAT_NUM_W-1:0] sat_num;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/rhc_pixel_if.sv
// ----------------------------------------------------------------------------
// rhc_pixel_if
// Valid/ready channel carrying one RGB pixel.
// ----------------------------------------------------------------------------
interface rhc_pixel_if;
  import rhc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);

endinterface

>>> hdl/rhc_hsv_if.sv
// ----------------------------------------------------------------------------
// rhc_hsv_if
// Valid/ready channel carrying one HSV result.
// ----------------------------------------------------------------------------
interface rhc_hsv_if;
  import rhc_pkg::*;

  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [SAT_W-1:0]  saturation;
  logic [CHAN_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);

endinterface

>>> hdl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// 8-bit RGB pixel to fixed-point HSV, one pixel per clock unless hsv stalls.
//
//   channel  dir  payload                            transfer
//   pixel    in   red, green, blue (8b each)         valid & ready
//   hsv      out  hue (16b), saturation (16b),       valid & ready
//                 brightness (8b)
//
// One pixel per cycle sustained while hsv is ready; a pixel passes the
// classify register, queue slot, lookup, multiply, back-multiply and output
// register in turn.
// Divides use reciprocal tables and a single-step correction.
// Synchronous reset clears all valid flags and the queue pointers.
// A stall on hsv holds the divide pipeline; the queue between front and
// back keeps taking pixels until it fills.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_assert.svh"

module rgb_to_hsv_converter #(
  parameter int QUEUE_DEPTH = rhc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  rhc_pixel_if.sink   pixel,
  rhc_hsv_if.source   hsv
);
  import rhc_pkg::*;

  item_t     push_item, pop_item;
  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  q_status_t q_status;

  rhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  rhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .status     (q_status)
  );

  rhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .hsv       (hsv)
  );

  `RHC_ASSERT_NOW(a_black_zero, hsv.valid && (hsv.brightness == '0),
                  (hsv.saturation == '0) && (hsv.hue == '0),
                  "black pixel with nonzero hue or saturation")
  `RHC_ASSERT_NOW(a_unsat_grey, hsv.valid && (hsv.saturation == '0), hsv.hue == '0,
                  "zero saturation with nonzero hue")
  `RHC_ASSERT_NEXT(a_full_holds, q_status.full, !q_status.empty,
                   "queue emptied straight after full")

endmodule

>>> hdl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Accepts pixels, finds max/min and hue sector, forms both dividends.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic             clk,
  input  logic             rst,
  rhc_pixel_if.sink        pixel,
  output rhc_pkg::item_t   push_item,
  output logic             push_valid,
  input  logic             push_ready
);
  import rhc_pkg::*;

  logic [CHAN_W-1:0]    r, g, b;
  logic                 red_max, green_max;
  logic [CHAN_W-1:0]    mx, mn, delta;
  logic [N_W-1:0]       d11, three_d, six_d, n;
  item_t                item_next;
  item_t                item;
  logic                 vld;

  assign r = pixel.red;
  assign g = pixel.green;
  assign b = pixel.blue;

  always_comb begin
    red_max   = (r >= g) && (r >= b);
    green_max = !red_max && (g >= b);
    mx        = red_max ? r : (green_max ? g : b);
    mn        = r;
    if (g < mn) begin
      mn = g;
    end
    if (b < mn) begin
      mn = b;
    end
    delta   = mx - mn;
    d11     = N_W'(delta);
    three_d = (d11 << 1) + d11;
    six_d   = three_d << 1;
    if (red_max) begin
      n = (g >= b) ? N_W'(g - b) : six_d - N_W'(b - g);
    end else if (green_max) begin
      n = (d11 << 1) + N_W'(b) - N_W'(r);
    end else begin
      n = (d11 << 2) + N_W'(r) - N_W'(g);
    end
    item_next.brightness = mx;
    item_next.delta      = delta;
    item_next.grey       = (delta == '0);
    item_next.hue_num    = {n, {HUE_NUM_W-N_W{1'b0}}} + HUE_NUM_W'(three_d);
    item_next.sat_num    = {delta, {SAT_NUM_W-CHAN_W{1'b0}}}
                           - SAT_NUM_W'({delta, 1'b0}) + SAT_NUM_W'(mx);
  end

  assign pixel.ready = !vld || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (pixel.ready) begin
      vld <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      item <= item_next;
    end
  end

  assign push_item  = item;
  assign push_valid = vld;

endmodule

>>> hdl/rhc_queue.sv
// ----------------------------------------------------------------------------
// rhc_queue
// Short FIFO between the classify front and the divide back.
// ----------------------------------------------------------------------------
module rhc_queue #(
  parameter int DEPTH = rhc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  rhc_pkg::item_t      push_item,
  input  logic                push_valid,
  output logic                push_ready,
  output rhc_pkg::item_t      pop_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output rhc_pkg::q_status_t  status
);
  import rhc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign push_ready   = !status.full;
  assign pop_valid    = !status.empty;
  assign pop_item     = mem[rd_ptr];
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hdl/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Reciprocal divide pipeline: lookup, multiply, back-multiply, correct.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic             clk,
  input  logic             rst,
  input  rhc_pkg::item_t   pop_item,
  input  logic             pop_valid,
  output logic             pop_ready,
  rhc_hsv_if.source        hsv
);
  import rhc_pkg::*;

  localparam int HUE_PROD_W = HUE_NUM_W + RCP_W;
  localparam int SAT_PROD_W = SAT_NUM_W + RCP_W;
  localparam int HUE_QD_W   = HUE_Q_W + HUE_DIV_W;
  localparam int SAT_QD_W   = SAT_Q_W + SAT_DIV_W;

  // floor(2^32 / (6*d)) and floor(2^32 / (2*m)), zero at index 0
  logic [RCP_W-1:0] hue_rcp_tab [CHAN_LEVELS];
  logic [RCP_W-1:0] sat_rcp_tab [CHAN_LEVELS];

  for (genvar i = 0; i < CHAN_LEVELS; i++) begin : g_rcp
    localparam logic [RCP_W:0] HueDen = (i == 0) ? (RCP_W+1)'(1) : (RCP_W+1)'(6 * i);
    localparam logic [RCP_W:0] SatDen = (i == 0) ? (RCP_W+1)'(1) : (RCP_W+1)'(2 * i);
    localparam logic [RCP_W:0] HueRcp = RCP_ONE / HueDen;
    localparam logic [RCP_W:0] SatRcp = RCP_ONE / SatDen;
    assign hue_rcp_tab[i] = (i == 0) ? '0 : HueRcp[RCP_W-1:0];
    assign sat_rcp_tab[i] = (i == 0) ? '0 : SatRcp[RCP_W-1:0];
  end

  logic advance;

  // stage a
  logic                 a_vld, a_grey;
  logic [CHAN_W-1:0]    a_bri;
  logic [HUE_NUM_W-1:0] a_hue_num;
  logic [SAT_NUM_W-1:0] a_sat_num;
  logic [HUE_DIV_W-1:0] a_hue_div;
  logic [SAT_DIV_W-1:0] a_sat_div;
  logic [RCP_W-1:0]     a_hue_rcp, a_sat_rcp;

  // stage b
  logic                 b_vld, b_grey;
  logic [CHAN_W-1:0]    b_bri;
  logic [HUE_NUM_W-1:0] b_hue_num;
  logic [SAT_NUM_W-1:0] b_sat_num;
  logic [HUE_DIV_W-1:0] b_hue_div;
  logic [SAT_DIV_W-1:0] b_sat_div;
  logic [HUE_Q_W-1:0]   b_hue_qe;
  logic [SAT_Q_W-1:0]   b_sat_qe;
  logic [HUE_PROD_W-1:0] hue_prod;
  logic [SAT_PROD_W-1:0] sat_prod;

  // stage c
  logic                 c_vld, c_grey;
  logic [CHAN_W-1:0]    c_bri;
  logic [HUE_NUM_W-1:0] c_hue_num;
  logic [SAT_NUM_W-1:0] c_sat_num;
  logic [HUE_DIV_W-1:0] c_hue_div;
  logic [SAT_DIV_W-1:0] c_sat_div;
  logic [HUE_Q_W-1:0]   c_hue_qe;
  logic [SAT_Q_W-1:0]   c_sat_qe;
  logic [HUE_QD_W-1:0]  c_hue_qd;
  logic [SAT_QD_W-1:0]  c_sat_qd;
  logic [HUE_QD_W-1:0]  hue_qd;
  logic [SAT_QD_W-1:0]  sat_qd;

  // correction
  logic [HUE_NUM_W-1:0] hue_rem;
  logic [SAT_NUM_W-1:0] sat_rem;
  logic [HUE_Q_W-1:0]   hue_q;
  logic [SAT_Q_W-1:0]   sat_q;

  // output register
  logic                 o_vld;
  logic [HUE_W-1:0]     o_hue;
  logic [SAT_W-1:0]     o_sat;
  logic [CHAN_W-1:0]    o_bri;

  assign advance   = !o_vld || hsv.ready;
  assign pop_ready = advance;

  assign hue_prod = HUE_PROD_W'(a_hue_num) * HUE_PROD_W'(a_hue_rcp);
  assign sat_prod = SAT_PROD_W'(a_sat_num) * SAT_PROD_W'(a_sat_rcp);
  assign hue_qd   = HUE_QD_W'(b_hue_qe) * HUE_QD_W'(b_hue_div);
  assign sat_qd   = SAT_QD_W'(b_sat_qe) * SAT_QD_W'(b_sat_div);

  // estimate is the quotient or one below it
  always_comb begin
    hue_rem = c_hue_num - c_hue_qd[HUE_NUM_W-1:0];
    sat_rem = c_sat_num - SAT_NUM_W'(c_sat_qd);
    hue_q   = c_hue_qe + HUE_Q_W'(hue_rem >= HUE_NUM_W'(c_hue_div));
    sat_q   = c_sat_qe + SAT_Q_W'(sat_rem >= SAT_NUM_W'(c_sat_div));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      o_vld <= 1'b0;
    end else if (advance) begin
      a_vld <= pop_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      o_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_grey    <= pop_item.grey;
      a_bri     <= pop_item.brightness;
      a_hue_num <= pop_item.hue_num;
      a_sat_num <= pop_item.sat_num;
      a_hue_div <= (HUE_DIV_W'(pop_item.delta) << 2) + (HUE_DIV_W'(pop_item.delta) << 1);
      a_sat_div <= {pop_item.brightness, 1'b0};
      a_hue_rcp <= hue_rcp_tab[pop_item.delta];
      a_sat_rcp <= sat_rcp_tab[pop_item.brightness];

      b_grey    <= a_grey;
      b_bri     <= a_bri;
      b_hue_num <= a_hue_num;
      b_sat_num <= a_sat_num;
      b_hue_div <= a_hue_div;
      b_sat_div <= a_sat_div;
      b_hue_qe  <= hue_prod[RCP_W +: HUE_Q_W];
      b_sat_qe  <= sat_prod[RCP_W +: SAT_Q_W];

      c_grey    <= b_grey;
      c_bri     <= b_bri;
      c_hue_num <= b_hue_num;
      c_sat_num <= b_sat_num;
      c_hue_div <= b_hue_div;
      c_sat_div <= b_sat_div;
      c_hue_qe  <= b_hue_qe;
      c_sat_qe  <= b_sat_qe;
      c_hue_qd  <= hue_qd;
      c_sat_qd  <= sat_qd;

      // a full turn wraps to zero
      o_hue <= c_grey ? '0 : hue_q[HUE_W-1:0];
      o_sat <= c_grey ? '0 : sat_q;
      o_bri <= c_bri;
    end
  end

  assign hsv.valid      = o_vld;
  assign hsv.hue        = o_hue;
  assign hsv.saturation = o_sat;
  assign hsv.brightness = o_bri;

endmodule
